### hw/rtl/mabsg_pkg.sv
package mabsg_pkg;

   localparam int unsigned AXES_DEFAULT = 6;
   localparam int unsigned QUEUE_DEPTH  = 2;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_HEADER = 2'd1,
      CMD_STEPS  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   localparam logic CSR_STEP_INV = 1'b0;
   localparam logic CSR_DIR_INV  = 1'b1;

   // One decoded word passed from the front end to the execution unit.
   typedef struct packed {
      cmd_type     cmd;
      logic [2:0]  axis_index;
      logic [31:0] axis_steps;
      logic [15:0] seg_steps;
      logic [15:0] timer_delay;
      logic [7:0]  block_tag;
      logic [31:0] event_count;
      logic [7:0]  dir_bits;
      logic        backlash;
      logic [31:0] src_line;
      logic [31:0] sequence_req;
   } word_type;

   typedef struct packed {
      logic [7:0]  step_pins;
      logic [7:0]  dir_pins;
      logic        running;
      logic [15:0] timer_period;
      logic [31:0] exec_line;
      logic [31:0] current_seq;
      logic [31:0] last_seq;
      logic [31:0] position;
      logic        segment_done;
   } result_type;

endpackage

### hw/rtl/mabsg_front.sv
module mabsg_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  mabsg_pkg::word_type  in_word,
   output logic                 q_valid,
   input  logic                 q_ready,
   output mabsg_pkg::word_type  q_word
);

   localparam int unsigned PtrW = $clog2(mabsg_pkg::QUEUE_DEPTH);

   mabsg_pkg::word_type mem_ff [mabsg_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]   count_ff, count_in;
   logic            push, pop;

   assign in_ready = (count_ff != (PtrW+1)'(mabsg_pkg::QUEUE_DEPTH));
   assign push     = in_valid && in_ready;
   assign q_valid  = (count_ff != '0);
   assign pop      = q_valid && q_ready;
   assign q_word   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PtrW+1)'(mabsg_pkg::QUEUE_DEPTH))
      else $error("queue overfilled");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + (PtrW+1)'(1))
      else $error("queue count lost a push");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      !q_valid |=> count_ff <= (PtrW+1)'(1))
      else $error("queue count jumped");

endmodule

### hw/rtl/mabsg_exec.sv
module mabsg_exec #(
   parameter int unsigned AXES = mabsg_pkg::AXES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [0:0]             csr_idx,
   input  logic [7:0]             csr_data,
   input  logic                   q_valid,
   output logic                   q_ready,
   input  mabsg_pkg::word_type    q_word,
   output logic                   out_valid,
   input  logic                   out_ready,
   output mabsg_pkg::result_type  out_res
);

   logic [7:0]  step_inv_ff, dir_inv_ff;
   logic [7:0]  step_lvl_ff, step_lvl_in;
   logic [7:0]  dir_latch_ff, dir_latch_in;
   logic [7:0]  dir_port_ff, dir_port_in;
   logic        dir_written_ff, dir_written_in;
   logic        running_ff, running_in;
   logic [31:0] counter_ff [AXES];
   logic [31:0] counter_in [AXES];
   logic [31:0] pos_ff [AXES];
   logic [31:0] pos_in [AXES];
   logic        act_valid_ff, act_valid_in;
   logic [15:0] act_rem_ff, act_rem_in;
   logic [31:0] act_steps_ff [AXES];
   logic [31:0] act_steps_in [AXES];
   logic [15:0] act_timer_ff, act_timer_in;
   logic [7:0]  act_dir_ff, act_dir_in;
   logic        act_back_ff, act_back_in;
   logic [31:0] act_ev_ff, act_ev_in;
   logic        pend_valid_ff, pend_valid_in;
   logic [31:0] pend_steps_ff [AXES];
   logic [15:0] pend_seg_ff, pend_timer_ff;
   logic [7:0]  pend_tag_ff, pend_dir_ff;
   logic        pend_back_ff;
   logic [31:0] pend_ev_ff, pend_line_ff, pend_seq_ff;
   logic [8:0]  last_tag_ff, last_tag_in;
   logic [31:0] line_ff, line_in, cur_seq_ff, cur_seq_in, last_seq_ff, last_seq_in;
   logic        done;
   logic [7:0]  step_out, bits;
   logic        take, new_tag;
   logic [31:0] sum;
   logic [31:0] pos_sel;
   logic        res_valid_ff;
   mabsg_pkg::result_type res_ff, res_in;

   assign q_ready   = !res_valid_ff || out_ready;
   assign take      = q_valid && q_ready;
   assign out_valid = res_valid_ff;
   assign out_res   = res_ff;

   always_comb begin
      step_lvl_in    = step_lvl_ff;
      dir_latch_in   = dir_latch_ff;
      dir_port_in    = dir_port_ff;
      dir_written_in = dir_written_ff;
      running_in     = running_ff;
      counter_in     = counter_ff;
      pos_in         = pos_ff;
      act_valid_in   = act_valid_ff;
      act_rem_in     = act_rem_ff;
      act_steps_in   = act_steps_ff;
      act_timer_in   = act_timer_ff;
      act_dir_in     = act_dir_ff;
      act_back_in    = act_back_ff;
      act_ev_in      = act_ev_ff;
      pend_valid_in  = pend_valid_ff;
      last_tag_in    = last_tag_ff;
      line_in        = line_ff;
      cur_seq_in     = cur_seq_ff;
      last_seq_in    = last_seq_ff;
      done           = 1'b0;
      step_out       = '0;
      bits           = '0;
      new_tag        = 1'b0;
      sum            = '0;
      case (q_word.cmd)
         mabsg_pkg::CMD_HEADER: begin
            pend_valid_in = 1'b1;
            if (!running_ff) begin
               running_in  = 1'b1;
               step_lvl_in = step_inv_ff;
            end
         end
         mabsg_pkg::CMD_TICK: begin
            if (!dir_written_ff) begin
               dir_port_in    = dir_latch_ff;
               dir_written_in = 1'b1;
            end
            step_out = step_lvl_ff;
            if (!act_valid_ff) begin
               if (pend_valid_ff) begin
                  act_timer_in  = pend_timer_ff;
                  act_dir_in    = pend_dir_ff;
                  act_back_in   = pend_back_ff;
                  act_ev_in     = pend_ev_ff;
                  act_rem_in    = pend_seg_ff;
                  act_steps_in  = pend_steps_ff;
                  act_valid_in  = 1'b1;
                  pend_valid_in = 1'b0;
                  new_tag = ({1'b1, pend_tag_ff} != last_tag_ff);
                  if (new_tag) begin
                     dir_written_in = 1'b0;
                     line_in        = pend_line_ff;
                     last_seq_in    = cur_seq_ff;
                     cur_seq_in     = pend_seq_ff;
                     last_tag_in    = {1'b1, pend_tag_ff};
                     for (int i = 0; i < AXES; i++) begin
                        counter_in[i] = pend_ev_ff;
                     end
                  end
                  dir_latch_in = pend_dir_ff ^ dir_inv_ff;
               end else begin
                  running_in     = 1'b0;
                  last_seq_in    = cur_seq_ff;
                  cur_seq_in     = '0;
                  dir_written_in = 1'b0;
                  step_lvl_in    = '0;
               end
            end
            if (act_valid_in) begin
               // Axes are independent, so each gets its own adder and compare.
               for (int i = 0; i < AXES; i++) begin
                  sum = counter_in[i] + act_steps_in[i];
                  counter_in[i] = sum;
                  if (sum > act_ev_in) begin
                     bits[i]       = 1'b1;
                     counter_in[i] = sum - act_ev_in;
                     if (!act_back_in) begin
                        pos_in[i] = act_dir_in[i] ? pos_ff[i] - 32'd1
                                                  : pos_ff[i] + 32'd1;
                     end
                  end
               end
               if (act_rem_in <= 16'd1) begin
                  act_rem_in   = '0;
                  act_valid_in = 1'b0;
                  done         = 1'b1;
               end else begin
                  act_rem_in = act_rem_in - 16'd1;
               end
               step_lvl_in = bits ^ step_inv_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      pos_sel = '0;
      for (int i = 0; i < AXES; i++) begin
         if (q_word.axis_index == 3'(i)) begin
            pos_sel = pos_in[i];
         end
      end
      res_in.step_pins    = step_out;
      res_in.dir_pins     = dir_port_in;
      res_in.running      = running_in;
      res_in.timer_period = act_timer_in;
      res_in.exec_line    = line_in;
      res_in.current_seq  = cur_seq_in;
      res_in.last_seq     = last_seq_in;
      res_in.position     = pos_sel;
      res_in.segment_done = done;
   end

   always_ff @(posedge clock) begin
      if (take) begin
         res_ff <= res_in;
         if (q_word.cmd == mabsg_pkg::CMD_HEADER) begin
            pend_seg_ff   <= q_word.seg_steps;
            pend_timer_ff <= q_word.timer_delay;
            pend_tag_ff   <= q_word.block_tag;
            pend_dir_ff   <= q_word.dir_bits;
            pend_back_ff  <= q_word.backlash;
            pend_ev_ff    <= q_word.event_count;
            pend_line_ff  <= q_word.src_line;
            pend_seq_ff   <= q_word.sequence_req;
         end
         for (int i = 0; i < AXES; i++) begin
            if (q_word.cmd == mabsg_pkg::CMD_STEPS && q_word.axis_index == 3'(i)) begin
               pend_steps_ff[i] <= q_word.axis_steps;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_inv_ff    <= '0;
         dir_inv_ff     <= '0;
         step_lvl_ff    <= '0;
         dir_latch_ff   <= '0;
         dir_port_ff    <= '0;
         dir_written_ff <= 1'b0;
         running_ff     <= 1'b0;
         act_valid_ff   <= 1'b0;
         act_rem_ff     <= '0;
         act_timer_ff   <= '0;
         act_dir_ff     <= '0;
         act_back_ff    <= 1'b0;
         act_ev_ff      <= '0;
         pend_valid_ff  <= 1'b0;
         last_tag_ff    <= '0;
         line_ff        <= '0;
         cur_seq_ff     <= '0;
         last_seq_ff    <= '0;
         res_valid_ff   <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            counter_ff[i]   <= '0;
            pos_ff[i]       <= '0;
            act_steps_ff[i] <= '0;
         end
      end else begin
         if (csr_we && csr_idx == mabsg_pkg::CSR_STEP_INV) begin
            step_inv_ff <= csr_data;
         end
         if (csr_we && csr_idx == mabsg_pkg::CSR_DIR_INV) begin
            dir_inv_ff <= csr_data;
         end
         if (take) begin
            step_lvl_ff    <= step_lvl_in;
            dir_latch_ff   <= dir_latch_in;
            dir_port_ff    <= dir_port_in;
            dir_written_ff <= dir_written_in;
            running_ff     <= running_in;
            counter_ff     <= counter_in;
            pos_ff         <= pos_in;
            act_valid_ff   <= act_valid_in;
            act_rem_ff     <= act_rem_in;
            act_steps_ff   <= act_steps_in;
            act_timer_ff   <= act_timer_in;
            act_dir_ff     <= act_dir_in;
            act_back_ff    <= act_back_in;
            act_ev_ff      <= act_ev_in;
            pend_valid_ff  <= pend_valid_in;
            last_tag_ff    <= last_tag_in;
            line_ff        <= line_in;
            cur_seq_ff     <= cur_seq_in;
            last_seq_ff    <= last_seq_in;
         end
         if (take) begin
            res_valid_ff <= 1'b1;
         end else if (out_ready) begin
            res_valid_ff <= 1'b0;
         end
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(res_ff))
      else $error("result dropped while stalled");
   a_idle_seq: assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> cur_seq_ff == '0 || last_tag_ff[8])
      else $error("sequence set without a block");
   a_done_tick: assert property (@(posedge clock) disable iff (reset)
      out_valid && res_ff.segment_done |-> !act_valid_ff || $past(take))
      else $error("segment done without a tick");
   a_active_running: assert property (@(posedge clock) disable iff (reset)
      act_valid_ff |-> running_ff)
      else $error("segment active while shut down");

endmodule

### hw/rtl/multi_axis_bresenham_step_generator_top.sv
// Path: an accepted word is written into the front queue, then the execution
// unit takes it and registers the result, which is presented on the result port
// and is held there until it is taken.
// Throughput: one word per cycle unless the result port stalls; all axis adders
// update in parallel in the cycle a word is taken. Reset is synchronous and active
// high: it clears the queue, the masks, all counters, positions and sequence state.
module multi_axis_bresenham_step_generator_top #(
   parameter int unsigned AXES = mabsg_pkg::AXES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [0:0]  csr_idx,
   input  logic [7:0]  csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [2:0]  req_axis_index,
   input  logic [31:0] req_axis_steps,
   input  logic [15:0] req_seg_steps,
   input  logic [15:0] req_timer_delay,
   input  logic [7:0]  req_block_tag,
   input  logic [31:0] req_event_count,
   input  logic [7:0]  req_dir_bits,
   input  logic        req_backlash,
   input  logic [31:0] req_src_line,
   input  logic [31:0] req_sequence_req,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_step_pins,
   output logic [7:0]  rsp_dir_pins,
   output logic        rsp_running,
   output logic [15:0] rsp_timer_period,
   output logic [31:0] rsp_exec_line,
   output logic [31:0] rsp_current_seq,
   output logic [31:0] rsp_last_seq,
   output logic signed [31:0] rsp_position,
   output logic        rsp_segment_done
);

   mabsg_pkg::word_type   in_word, q_word;
   mabsg_pkg::result_type res;
   logic                  q_valid, q_ready;

   always_comb begin
      in_word.cmd          = mabsg_pkg::cmd_type'(req_cmd);
      in_word.axis_index   = req_axis_index;
      in_word.axis_steps   = req_axis_steps;
      in_word.seg_steps    = req_seg_steps;
      in_word.timer_delay  = req_timer_delay;
      in_word.block_tag    = req_block_tag;
      in_word.event_count  = req_event_count;
      in_word.dir_bits     = req_dir_bits;
      in_word.backlash     = req_backlash;
      in_word.src_line     = req_src_line;
      in_word.sequence_req = req_sequence_req;
   end

   mabsg_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_ready (req_ready),
      .in_word  (in_word),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_word   (q_word)
   );

   mabsg_exec #(.AXES(AXES)) u_exec (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_data  (csr_data),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_word    (q_word),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_res   (res)
   );

   assign rsp_step_pins    = res.step_pins;
   assign rsp_dir_pins     = res.dir_pins;
   assign rsp_running      = res.running;
   assign rsp_timer_period = res.timer_period;
   assign rsp_exec_line    = res.exec_line;
   assign rsp_current_seq  = res.current_seq;
   assign rsp_last_seq     = res.last_seq;
   assign rsp_position     = signed'(res.position);
   assign rsp_segment_done = res.segment_done;

endmodule

### verif/tb_multi_axis_bresenham_step_generator_top.sv
module tb_multi_axis_bresenham_step_generator_top;

   localparam int NAXES     = 6;
   localparam int CYCLE_CAP = 500000;

   typedef struct {
      mabsg_pkg::word_type   w;
      bit                    typed;
      mabsg_pkg::result_type r;
   } vector_row;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [0:0]            csr_idx = mabsg_pkg::CSR_STEP_INV;
   logic [7:0]            csr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   mabsg_pkg::word_type   req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   mabsg_pkg::result_type rsp_word;

   multi_axis_bresenham_step_generator_top uut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_data(csr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_cmd(req_word.cmd), .req_axis_index(req_word.axis_index),
      .req_axis_steps(req_word.axis_steps), .req_seg_steps(req_word.seg_steps),
      .req_timer_delay(req_word.timer_delay), .req_block_tag(req_word.block_tag),
      .req_event_count(req_word.event_count), .req_dir_bits(req_word.dir_bits),
      .req_backlash(req_word.backlash), .req_src_line(req_word.src_line),
      .req_sequence_req(req_word.sequence_req),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_step_pins(rsp_word.step_pins), .rsp_dir_pins(rsp_word.dir_pins),
      .rsp_running(rsp_word.running), .rsp_timer_period(rsp_word.timer_period),
      .rsp_exec_line(rsp_word.exec_line), .rsp_current_seq(rsp_word.current_seq),
      .rsp_last_seq(rsp_word.last_seq), .rsp_position(rsp_word.position),
      .rsp_segment_done(rsp_word.segment_done)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state of the step generator.
   logic [7:0]  step_inv, dir_inv;
   logic [7:0]  step_level, dir_latch, dir_port;
   logic        dir_written, running_now;
   logic [31:0] bres_count [NAXES];
   logic [31:0] axis_pos [NAXES];
   logic        seg_active;
   logic [15:0] seg_left;
   logic [31:0] seg_axis_steps [NAXES];
   mabsg_pkg::word_type seg_hdr;
   logic        staged_valid;
   logic [31:0] staged_steps [NAXES];
   mabsg_pkg::word_type staged_hdr;
   logic        tag_seen;
   logic [7:0]  tag_last;
   logic [31:0] line_now, seq_now, seq_done;

   mabsg_pkg::result_type expected_reports [$];
   int          mismatches = 0;
   int          reports_seen = 0;
   int          ticks_sent = 0;
   int          segments_done = 0;
   int          cycles = 0;
   bit          burst_mode = 0;
   bit          long_hold = 0;

   function automatic mabsg_pkg::result_type port_state_after(mabsg_pkg::word_type w);
      mabsg_pkg::result_type r;
      logic [7:0] bits;
      r = '0;
      case (w.cmd)
         mabsg_pkg::CMD_HEADER: begin
            staged_hdr = w;
            staged_valid = 1'b1;
            if (!running_now) begin
               running_now = 1'b1;
               step_level = step_inv;
            end
         end
         mabsg_pkg::CMD_STEPS: begin
            if (w.axis_index < NAXES) staged_steps[w.axis_index] = w.axis_steps;
         end
         mabsg_pkg::CMD_TICK: begin
            if (!dir_written) begin
               dir_port = dir_latch;
               dir_written = 1'b1;
            end
            r.step_pins = step_level;
            if (!seg_active) begin
               if (staged_valid) begin
                  seg_hdr = staged_hdr;
                  seg_left = staged_hdr.seg_steps;
                  for (int i = 0; i < NAXES; i++) seg_axis_steps[i] = staged_steps[i];
                  seg_active = 1'b1;
                  staged_valid = 1'b0;
                  if (!tag_seen || tag_last != staged_hdr.block_tag) begin
                     dir_written = 1'b0;
                     line_now = staged_hdr.src_line;
                     seq_done = seq_now;
                     seq_now = staged_hdr.sequence_req;
                     tag_seen = 1'b1;
                     tag_last = staged_hdr.block_tag;
                     for (int i = 0; i < NAXES; i++) bres_count[i] = staged_hdr.event_count;
                  end
                  dir_latch = staged_hdr.dir_bits ^ dir_inv;
               end else begin
                  running_now = 1'b0;
                  seq_done = seq_now;
                  seq_now = '0;
                  dir_written = 1'b0;
                  step_level = '0;
               end
            end
            if (seg_active) begin
               bits = '0;
               for (int i = 0; i < NAXES; i++) begin
                  bres_count[i] = bres_count[i] + seg_axis_steps[i];
                  if (bres_count[i] > seg_hdr.event_count) begin
                     bits[i] = 1'b1;
                     bres_count[i] = bres_count[i] - seg_hdr.event_count;
                     if (!seg_hdr.backlash)
                        axis_pos[i] = seg_hdr.dir_bits[i] ? axis_pos[i] - 32'd1
                                                          : axis_pos[i] + 32'd1;
                  end
               end
               if (seg_left <= 16'd1) begin
                  seg_left = '0;
                  seg_active = 1'b0;
                  r.segment_done = 1'b1;
               end else begin
                  seg_left = seg_left - 16'd1;
               end
               step_level = bits ^ step_inv;
            end
         end
         default: ;
      endcase
      r.dir_pins = dir_port;
      r.running = running_now;
      r.timer_period = seg_hdr.timer_delay;
      r.exec_line = line_now;
      r.current_seq = seq_now;
      r.last_seq = seq_done;
      r.position = (w.axis_index < NAXES) ? axis_pos[w.axis_index] : '0;
      return r;
   endfunction

   function automatic mabsg_pkg::word_type make_word(mabsg_pkg::cmd_type c, int axis,
                                          logic [31:0] steps,
                                          logic [15:0] seg, logic [15:0] timer,
                                          logic [7:0] tag, logic [31:0] ev,
                                          logic [7:0] dir, logic bl,
                                          logic [31:0] line, logic [31:0] seq);
      mabsg_pkg::word_type w;
      w.cmd = c; w.axis_index = 3'(axis); w.axis_steps = steps; w.seg_steps = seg;
      w.timer_delay = timer; w.block_tag = tag; w.event_count = ev; w.dir_bits = dir;
      w.backlash = bl; w.src_line = line; w.sequence_req = seq;
      return w;
   endfunction

   function automatic mabsg_pkg::word_type random_word(mabsg_pkg::cmd_type c);
      mabsg_pkg::word_type w;
      w = make_word(c, $urandom_range(0, 7), $urandom, 16'($urandom), 16'($urandom),
                    8'($urandom), $urandom, 8'($urandom), 1'($urandom), $urandom,
                    $urandom);
      return w;
   endfunction

   // Present one word after a random gap; valid stays high across back-to-back words.
   task automatic send(mabsg_pkg::word_type w, bit typed = 0,
                       mabsg_pkg::result_type typed_r = '0);
      int gap;
      mabsg_pkg::result_type r;
      gap = burst_mode ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
      r = port_state_after(w);
      expected_reports.push_back(typed ? typed_r : r);
      if (w.cmd == mabsg_pkg::CMD_TICK) ticks_sent++;
   endtask

   task automatic settle;
      if (req_valid) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mask(logic [0:0] idx, logic [7:0] data);
      settle();
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == mabsg_pkg::CSR_STEP_INV) step_inv = data; else dir_inv = data;
   endtask

   // Receiver: random stall per word, and once a long hold to back the block up.
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = $urandom_range(0, 16);
         if (burst_mode) stall = 0;
         if (long_hold) begin
            stall = 300;
            long_hold = 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         reports_seen++;
         if (expected_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result word: %p", rsp_word);
         end else begin
            mabsg_pkg::result_type e;
            e = expected_reports.pop_front();
            if (e.segment_done) segments_done++;
            if (rsp_word !== e) begin
               mismatches++;
               if (mismatches <= 10) $display("Mismatch at word %0d:\n  expected %p\n  actual   %p",
                                              reports_seen, e, rsp_word);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("Timeout with %0d results outstanding", expected_reports.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      vector_row           rows [$];
      vector_row           row;
      mabsg_pkg::word_type w;
      int                  sent;
      logic [31:0]         ev;
      logic [7:0]          tag;
      int                  nsteps, nticks;
      bit                  hold_done;
      bit                  paused;

      hold_done = 0; paused = 0;
      step_inv = '0; dir_inv = '0; step_level = '0; dir_latch = '0; dir_port = '0;
      dir_written = 0; running_now = 0; seg_active = 0; seg_left = '0; seg_hdr = '0;
      staged_valid = 0; staged_hdr = '0; tag_seen = 0; tag_last = '0;
      line_now = '0; seq_now = '0; seq_done = '0;
      for (int i = 0; i < NAXES; i++) begin
         bres_count[i] = '0; axis_pos[i] = '0; seg_axis_steps[i] = '0; staged_steps[i] = '0;
      end

      // Directed words; the first three answer with an all-zero state.
      row.typed = 1; row.r = '0;
      row.w = make_word(mabsg_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      rows.push_back(row);
      row.w = make_word(mabsg_pkg::CMD_NONE, 7, '1, '1, '1, '1, '1, '1, 1, '1, '1);
      rows.push_back(row);
      row.w = make_word(mabsg_pkg::CMD_STEPS, 7, '1, 0, 0, 0, 0, 0, 0, 0, 0);
      rows.push_back(row);
      row.typed = 0;
      row.w = make_word(mabsg_pkg::CMD_STEPS, 0, 32'd3, 0, 0, 0, 0, 0, 0, 0, 0);
      rows.push_back(row);
      row.w = make_word(mabsg_pkg::CMD_STEPS, 1, 32'd0, 0, 0, 0, 0, 0, 0, 0, 0);
      rows.push_back(row);
      row.w = make_word(mabsg_pkg::CMD_STEPS, 2, 32'd10, 0, 0, 0, 0, 0, 0, 0, 0);
      rows.push_back(row);
      row.w = make_word(mabsg_pkg::CMD_STEPS, 3, 32'd7, 0, 0, 0, 0, 0, 0, 0, 0);
      rows.push_back(row);
      row.w = make_word(mabsg_pkg::CMD_STEPS, 4, 32'd1, 0, 0, 0, 0, 0, 0, 0, 0);
      rows.push_back(row);
      row.w = make_word(mabsg_pkg::CMD_STEPS, 5, '1, 0, 0, 0, 0, 0, 0, 0, 0);
      rows.push_back(row);
      row.w = make_word(mabsg_pkg::CMD_HEADER, 0, 0, 16'd9, 16'hFFFF, 8'h00, 32'd10,
                        8'hAA, 0, '1, 32'd5);
      rows.push_back(row);
      // Restaging replaces the header waiting in the buffer.
      row.w = make_word(mabsg_pkg::CMD_HEADER, 0, 0, 16'd3, 16'h1234, 8'h01, 32'd10,
                        8'h15, 0, 32'd100, 32'd6);
      rows.push_back(row);
      for (int k = 0; k < 4; k++) begin
         row.w = make_word(mabsg_pkg::CMD_TICK, k + 2, 0, 0, 0, 0, 0, 0, 0, 0, 0);
         rows.push_back(row);
      end
      // Same tag, backlash, zero ticks: one tick only, counters carry on.
      row.w = make_word(mabsg_pkg::CMD_HEADER, 0, 0, 16'd0, 16'd0, 8'h01, 32'd10,
                        8'hFF, 1, 0, 32'hFFFFFFFF);
      rows.push_back(row);
      row.w = make_word(mabsg_pkg::CMD_TICK, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      rows.push_back(row);
      row.w = make_word(mabsg_pkg::CMD_TICK, 6, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      rows.push_back(row);
      row.w = make_word(mabsg_pkg::CMD_HEADER, 0, 0, 16'hFFFF, 16'd1, 8'hFF, '1,
                        8'h00, 0, 32'd7, 32'd8);
      rows.push_back(row);
      row.w = make_word(mabsg_pkg::CMD_STEPS, 3, '1, 0, 0, 0, 0, 0, 0, 0, 0);
      rows.push_back(row);
      row.w = make_word(mabsg_pkg::CMD_TICK, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      rows.push_back(row);
      row.w = make_word(mabsg_pkg::CMD_TICK, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      rows.push_back(row);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send(rows[i].w, rows[i].typed, rows[i].r);

      sent = 0;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_mask(mabsg_pkg::CSR_STEP_INV, 8'h00);
               write_mask(mabsg_pkg::CSR_DIR_INV, 8'h00);
            end
            1: begin
               write_mask(mabsg_pkg::CSR_STEP_INV, 8'hFF);
               write_mask(mabsg_pkg::CSR_DIR_INV, 8'hFF);
            end
            default: begin
               write_mask(mabsg_pkg::CSR_STEP_INV, 8'($urandom));
               write_mask(mabsg_pkg::CSR_DIR_INV, 8'($urandom));
            end
         endcase
         while (sent < 150 * (phase + 1)) begin
            if ($urandom_range(0, 7) == 0) burst_mode = !burst_mode;
            if (phase == 1 && !hold_done && sent >= 200) begin
               long_hold = 1;
               hold_done = 1;
            end
            if (phase == 2 && !paused && sent >= 350) begin
               settle();
               paused = 1;
            end
            if ($urandom_range(0, 9) == 0) begin
               w = random_word(mabsg_pkg::cmd_type'($urandom_range(0, 3)));
               send(w);
               if (!(w.cmd == mabsg_pkg::CMD_STEPS && w.axis_index >= NAXES)) sent++;
            end else begin
               case ($urandom_range(0, 3))
                  0: ev = $urandom;
                  1: ev = '1;
                  default: ev = $urandom_range(1, 20);
               endcase
               nsteps = $urandom_range(0, 6);
               for (int k = 0; k < nsteps; k++) begin
                  w = random_word(mabsg_pkg::CMD_STEPS);
                  if ($urandom_range(0, 3) != 0) w.axis_steps = $urandom_range(0, 24);
                  send(w);
                  if (w.axis_index < NAXES) sent++;
               end
               tag = ($urandom_range(0, 2) == 0) ? tag_last : 8'($urandom);
               w = random_word(mabsg_pkg::CMD_HEADER);
               w.block_tag = tag;
               w.event_count = ev;
               if ($urandom_range(0, 15) != 0) w.seg_steps = 16'($urandom_range(0, 6));
               send(w);
               sent++;
               nticks = $urandom_range(0, (w.seg_steps > 9) ? 12 : w.seg_steps + 3);
               for (int k = 0; k < nticks; k++) begin
                  send(random_word(mabsg_pkg::CMD_TICK));
                  sent++;
               end
            end
         end
      end
      burst_mode = 0;
      settle();
      repeat (10) @(posedge clock);

      $display("Sent %0d ticks among %0d words; %0d segments finished; masks at zero, ones, random.",
               ticks_sent, reports_seen, segments_done);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches in total", mismatches);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/mabsg_pkg.sv
hw/rtl/mabsg_front.sv
hw/rtl/mabsg_exec.sv
hw/rtl/multi_axis_bresenham_step_generator_top.sv
verif/tb_multi_axis_bresenham_step_generator_top.sv
